/* sv/bmm_pkg.sv */
package bmm_pkg;
  localparam int VW = 6;
  localparam int CW = 7;
  localparam int NV = 64;
  localparam logic [0:0] REG_LEFT  = 1'b0;
  localparam logic [0:0] REG_RIGHT = 1'b1;
endpackage

/* sv/bmm_core.sv */
module bmm_core
  import bmm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [VW-1:0] in_left,
  input  logic [VW-1:0] in_right,
  input  logic          in_edge,
  input  logic          in_last,
  input  logic [CW-1:0] left_count,
  input  logic [CW-1:0] right_count,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [VW-1:0] out_index,
  output logic [VW-1:0] out_partner,
  output logic          out_matched,
  output logic [CW-1:0] out_size,
  output logic          out_last
);
  typedef enum logic [10:0] {
    S_LOAD  = 11'h001, S_INIT = 11'h002, S_ROOT = 11'h004, S_SCAN = 11'h008,
    S_POP   = 11'h010, S_PUSH = 11'h020, S_AUGR = 11'h040, S_AUGW = 11'h080,
    S_FETCH = 11'h100, S_EMIT = 11'h200, S_CLR  = 11'h400
  } state_t;
  state_t state;

  logic [NV-1:0] adj_mem [NV];
  logic [NV-1:0] adj_q;
  logic [VW-1:0] adj_addr;
  logic          adj_we;
  logic [NV-1:0] adj_wd;
  logic [VW-1:0] partner [NV];
  logic [VW-1:0] par_q;
  logic [VW-1:0] par_ra;
  logic          par_we;
  logic [VW-1:0] stk_v [NV];
  logic [VW-1:0] stk_c [NV];
  logic [VW-1:0] stk_v_q, stk_c_q;
  logic [VW-1:0] stk_ra, stk_va, stk_vd, stk_ca;
  logic          stk_vwe, stk_cwe;
  logic [NV-1:0] used;
  logic [NV-1:0] visited;
  logic [CW-1:0] nl, nr, depth, root, pairs, k, ridx;
  logic [CW-1:0] dm1, dm2;
  logic [VW-1:0] cur_v;
  logic [NV-1:0] row;
  logic [NV-1:0] colmask, cand;
  logic [CW-1:0] cidx;
  logic          found;
  logic          rmw;     // write phase of a load edge beat
  logic [VW-1:0] rmw_a, rmw_c;

  // adjacency store: one row per left vertex, single port, registered read
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_addr] <= adj_wd;
    adj_q <= adj_mem[adj_addr];
  end

  // search stack: vertex and chosen column per level, registered read
  always_ff @(posedge clk) begin
    if (stk_vwe) stk_v[stk_va] <= stk_vd;
    if (stk_cwe) stk_c[stk_ca] <= cidx[VW-1:0];
    stk_v_q <= stk_v[stk_ra];
    stk_c_q <= stk_c[stk_ra];
  end

  // partner store: left vertex per right vertex, registered read
  always_ff @(posedge clk) begin
    if (par_we) partner[stk_c_q] <= stk_v_q;
    par_q <= partner[par_ra];
  end

  assign nl = (left_count  > CW'(NV)) ? CW'(NV) : left_count;
  assign nr = (right_count > CW'(NV)) ? CW'(NV) : right_count;
  assign dm1 = depth - CW'(1);
  assign dm2 = depth - CW'(2);

  always_comb begin
    colmask = '0;
    for (int i = 0; i < NV; i++) colmask[i] = (CW'(i) < nr);
    cand  = row & ~visited & colmask;
    found = |cand;
    cidx  = '0;
    for (int i = NV - 1; i >= 0; i--) if (cand[i]) cidx = CW'(i);
  end

  assign s_tready = (state == S_LOAD) && !rmw;

  // memory addresses and write strobes per state
  always_comb begin
    adj_we = 1'b0; adj_wd = adj_q | (NV'(1) << rmw_c); adj_addr = in_left;
    if (rmw) begin adj_we = 1'b1; adj_addr = rmw_a; end
    else if (state == S_ROOT) adj_addr = root[VW-1:0];
    else if (state == S_SCAN) adj_addr = cur_v;
    else if (state == S_POP) adj_addr = stk_v_q;
    else if (state == S_PUSH) adj_addr = par_q;
    else if (state == S_CLR) begin adj_we = 1'b1; adj_wd = '0; adj_addr = k[VW-1:0]; end
    par_ra  = (state == S_SCAN) ? cidx[VW-1:0] : ridx[VW-1:0];
    par_we  = (state == S_AUGW);
    stk_ra  = (state == S_SCAN) ? dm2[VW-1:0] : k[VW-1:0];
    stk_vwe = ((state == S_ROOT) && (root < nl)) || (state == S_PUSH);
    stk_va  = (state == S_PUSH) ? depth[VW-1:0] : '0;
    stk_vd  = (state == S_PUSH) ? par_q : root[VW-1:0];
    stk_cwe = (state == S_SCAN) && found;
    stk_ca  = dm1[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; k <= '0; rmw <= 1'b0; m_tvalid <= 1'b0; used <= '0;
    end else begin
      rmw <= 1'b0;
      case (state)
        S_LOAD: if (!rmw && s_tvalid) begin
          if (in_edge) begin
            rmw <= 1'b1; rmw_a <= in_left; rmw_c <= in_right;
          end
          if (in_last) state <= S_INIT;
        end
        S_INIT: if (!rmw) begin
          used <= '0; pairs <= '0; root <= '0; state <= S_ROOT;
        end
        S_ROOT: if (root >= nl) begin
          ridx <= '0; k <= '0;
          state <= (nr == '0) ? S_CLR : S_FETCH;
        end else begin
          visited <= '0; depth <= CW'(1);
          cur_v <= root[VW-1:0]; state <= S_SCAN;
        end
        S_SCAN: if (!found) begin
          // vertex exhausted: pop and rescan parent, or try the next root at the top
          if (depth == CW'(1)) begin root <= root + 1'b1; state <= S_ROOT; end
          else begin depth <= dm1; state <= S_POP; end
        end else begin
          visited[cidx[VW-1:0]] <= 1'b1;
          if (!used[cidx[VW-1:0]]) begin
            k <= '0; state <= S_AUGR;
          end else if (depth < CW'(NV)) begin
            state <= S_PUSH;
          end
        end
        S_POP: begin
          cur_v <= stk_v_q; state <= S_SCAN;
        end
        S_PUSH: begin
          cur_v <= par_q; depth <= depth + 1'b1; state <= S_SCAN;
        end
        S_AUGR: state <= S_AUGW;
        // flip one path edge per read/write pair (S_AUGR, S_AUGW)
        S_AUGW: begin
          used[stk_c_q] <= 1'b1;
          if (k + 1'b1 == depth) begin
            pairs <= pairs + 1'b1; root <= root + 1'b1; state <= S_ROOT;
          end else begin
            state <= S_AUGR;
          end
          k <= k + 1'b1;
        end
        // drop a beat taken while the next partner is read
        S_FETCH: begin
          if (m_tready) m_tvalid <= 1'b0;
          state <= S_EMIT;
        end
        S_EMIT: if (!m_tvalid || m_tready) begin
          if (ridx < nr) begin
            m_tvalid <= 1'b1;
            out_index <= ridx[VW-1:0];
            out_matched <= used[ridx[VW-1:0]];
            out_partner <= used[ridx[VW-1:0]] ? par_q : '0;
            out_size <= pairs; out_last <= (ridx + 1'b1 == nr);
            ridx <= ridx + 1'b1;
            state <= S_FETCH;
          end else begin
            m_tvalid <= 1'b0; k <= '0; state <= S_CLR;
          end
        end
        S_CLR: begin
          k <= k + 1'b1;
          if (k == CW'(NV - 1)) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // row used by the scan is the memory output
  assign row = adj_q;
endmodule

/* sv/bipartite_max_matching.sv */
// Maximum bipartite matching (augmenting-path search).
// Input stream s_*: while loading, an edge beat is accepted and then its
// adjacency row is read-modified-written, with input held off meanwhile; a
// beat without an edge is taken alone. Edges with an endpoint at or above
// MAX_VERTICES are dropped. The beat with tlast starts the search; input is
// then held off until all results are out and the 64-row adjacency store
// has been cleared. The search tries each left vertex in turn, scans its
// row, descends or backtracks, and flips an augmenting path when it finds one.
// Output stream m_*: one beat per right vertex below right_count, in order,
// each beat followed by a read of the next partner; the last beat carries
// tlast. A stalled receiver holds the beat and the block waits. cfg_* writes
// left_count/right_count (reset 64 each); write only while idle. Reset
// clears the store, with input held off, then loads.
module bipartite_max_matching
  import bmm_pkg::*;
#(
  parameter int MAX_VERTICES = 64
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // left_vertex[5:0], right_vertex[11:6], edge_valid[12]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // right_index[5:0], partner[11:6], is_matched[12],
                                 // matching_size[19:13]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int VCAP = (MAX_VERTICES < NV) ? MAX_VERTICES : NV;

  logic [CW-1:0] left_count, right_count, lc_eff, rc_eff;
  logic [VW-1:0] o_idx, o_par;
  logic          o_m;
  logic [CW-1:0] o_sz;
  logic          edge_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count <= CW'(64); right_count <= CW'(64);
    end else if (cfg_we) begin
      if (cfg_index == REG_LEFT) left_count <= cfg_data;
      else right_count <= cfg_data;
    end
  end

  assign lc_eff = (left_count  > CW'(VCAP)) ? CW'(VCAP) : left_count;
  assign rc_eff = (right_count > CW'(VCAP)) ? CW'(VCAP) : right_count;

  // drop edges beyond the store
  assign edge_ok = s_tdata[12] && (int'(s_tdata[5:0]) < VCAP)
                   && (int'(s_tdata[11:6]) < VCAP);

  bmm_core u_core (
    .clk, .rst, .s_tvalid, .s_tready,
    .in_left(s_tdata[5:0]), .in_right(s_tdata[11:6]), .in_edge(edge_ok),
    .in_last(s_tlast), .left_count(lc_eff), .right_count(rc_eff),
    .m_tvalid, .m_tready, .out_index(o_idx), .out_partner(o_par),
    .out_matched(o_m), .out_size(o_sz), .out_last(m_tlast)
  );

  assign m_tdata = {4'b0, o_sz, o_m, o_par, o_idx};
endmodule
